// ===== rtl/core/tagged_id_list_max_scanner_top_defines.svh =====
// assertion macros for the id list scanner
// no dependencies; included by the top level
`ifndef TAGGED_ID_LIST_MAX_SCANNER_TOP_DEFINES_SVH
`define TAGGED_ID_LIST_MAX_SCANNER_TOP_DEFINES_SVH

// same-cycle implication
`define TIDLMS_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tidlms assertion failed");

// next-cycle implication
`define TIDLMS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tidlms assertion failed");

`endif

// ===== rtl/core/tidlms_pkg.sv =====
// shared types and constants for the id list scanner
// no dependencies
package tidlms_pkg;

  localparam int ID_DIGITS = 6;
  localparam int DIG_W     = $clog2(ID_DIGITS + 1);
  localparam int VAL_W     = 20;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  typedef enum logic [2:0] {
    MODE_LINE_START = 3'd0,
    MODE_KEY_I      = 3'd1,
    MODE_KEY_D      = 3'd2,
    MODE_KEY_S      = 3'd3,
    MODE_SKIP_EOL   = 3'd4,
    MODE_WAIT_BRACE = 3'd5,
    MODE_IN_LIST    = 3'd6
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       file_start;
    logic       file_end;
  } in_beat_t;

  typedef struct packed {
    logic             token_found;
    logic [VAL_W-1:0] token_value;
    logic [VAL_W-1:0] max_value;
  } res_beat_t;

endpackage

// ===== rtl/core/tidlms_in_stage.sv =====
// input register stage for the id list scanner
// depends on tidlms_pkg
module tidlms_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  tidlms_pkg::in_beat_t up_beat,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output tidlms_pkg::in_beat_t dn_beat
);

  logic                 valid_r;
  tidlms_pkg::in_beat_t beat_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_valid && up_ready) begin
      valid_r <= 1'b1;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      beat_r <= up_beat;
    end
  end

endmodule

// ===== rtl/core/tidlms_scan.sv =====
// line/key/list scanner state and token decode, one byte per beat
// depends on tidlms_pkg
module tidlms_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  tidlms_pkg::in_beat_t  beat,
  output tidlms_pkg::res_beat_t res
);

  tidlms_pkg::scan_mode_t               mode_r, mode_nxt;
  logic                                 pws_r, pws_nxt;
  logic [tidlms_pkg::DIG_W-1:0]         dc_r, dc_nxt;
  logic                                 ta_r, ta_nxt;
  logic [tidlms_pkg::VAL_W-1:0]         acc_r, acc_nxt;
  logic [tidlms_pkg::VAL_W-1:0]         max_r, max_nxt;

  function automatic logic is_blank(input logic [7:0] c);
    return c == tidlms_pkg::CH_SPACE || c == tidlms_pkg::CH_TAB ||
           c == tidlms_pkg::CH_LF || c == tidlms_pkg::CH_VT ||
           c == tidlms_pkg::CH_FF || c == tidlms_pkg::CH_CR;
  endfunction

  function automatic logic is_stop(input logic [7:0] c);
    return c == tidlms_pkg::CH_LBRACE || c == tidlms_pkg::CH_RBRACE ||
           c == tidlms_pkg::CH_COMMA || c == tidlms_pkg::CH_SPACE ||
           c == tidlms_pkg::CH_TAB || c == tidlms_pkg::CH_LF;
  endfunction

  always_comb begin
    logic [7:0]                   c;
    logic                         found;
    logic [tidlms_pkg::VAL_W-1:0] value;
    logic                         digit;
    logic                         full;
    c     = beat.text_byte;
    found = 1'b0;
    value = '0;
    digit = (c >= tidlms_pkg::CH_0) && (c <= tidlms_pkg::CH_9);

    mode_nxt = mode_r;
    pws_nxt  = pws_r;
    dc_nxt   = dc_r;
    ta_nxt   = ta_r;
    acc_nxt  = acc_r;

    if (beat.file_start) begin
      mode_nxt = tidlms_pkg::MODE_LINE_START;
      pws_nxt  = 1'b1;
      dc_nxt   = '0;
      ta_nxt   = 1'b0;
      acc_nxt  = '0;
    end

    full = (dc_nxt == tidlms_pkg::DIG_W'(tidlms_pkg::ID_DIGITS));

    case (mode_nxt)
      tidlms_pkg::MODE_LINE_START: begin
        if (!is_blank(c)) begin
          mode_nxt = (c == tidlms_pkg::CH_I) ? tidlms_pkg::MODE_KEY_I
                                             : tidlms_pkg::MODE_SKIP_EOL;
        end
      end
      tidlms_pkg::MODE_KEY_I: begin
        if (c == tidlms_pkg::CH_D) begin
          mode_nxt = tidlms_pkg::MODE_KEY_D;
        end else begin
          mode_nxt = (c == tidlms_pkg::CH_LF) ? tidlms_pkg::MODE_LINE_START
                                              : tidlms_pkg::MODE_SKIP_EOL;
        end
      end
      tidlms_pkg::MODE_KEY_D: begin
        if (c == tidlms_pkg::CH_S) begin
          mode_nxt = tidlms_pkg::MODE_KEY_S;
        end else begin
          mode_nxt = (c == tidlms_pkg::CH_LF) ? tidlms_pkg::MODE_LINE_START
                                              : tidlms_pkg::MODE_SKIP_EOL;
        end
      end
      tidlms_pkg::MODE_KEY_S: begin
        mode_nxt = (is_blank(c) || c == tidlms_pkg::CH_EQ) ? tidlms_pkg::MODE_WAIT_BRACE
                                                           : tidlms_pkg::MODE_SKIP_EOL;
      end
      tidlms_pkg::MODE_SKIP_EOL: begin
        if (c == tidlms_pkg::CH_LF) begin
          mode_nxt = tidlms_pkg::MODE_LINE_START;
        end
      end
      tidlms_pkg::MODE_WAIT_BRACE: begin
        if (c == tidlms_pkg::CH_LBRACE) begin
          mode_nxt = tidlms_pkg::MODE_IN_LIST;
          pws_nxt  = 1'b1;
          ta_nxt   = 1'b0;
        end
      end
      default: begin
        if (ta_nxt) begin
          if (digit) begin
            if (!full) begin
              acc_nxt = (acc_nxt << 3) + (acc_nxt << 1) +
                        tidlms_pkg::VAL_W'(c[3:0]);
              dc_nxt  = dc_nxt + 1'b1;
            end else begin
              ta_nxt = 1'b0;
            end
            pws_nxt = 1'b0;
          end else begin
            if (is_stop(c) && full) begin
              found = 1'b1;
              value = acc_nxt;
            end
            ta_nxt  = 1'b0;
            pws_nxt = is_stop(c);
          end
        end else if (c == tidlms_pkg::CH_B && pws_nxt) begin
          ta_nxt  = 1'b1;
          dc_nxt  = '0;
          acc_nxt = '0;
        end else begin
          pws_nxt = is_stop(c);
        end
        if (c == tidlms_pkg::CH_RBRACE) begin
          ta_nxt   = 1'b0;
          mode_nxt = tidlms_pkg::MODE_SKIP_EOL;
        end
      end
    endcase

    if (beat.file_end) begin
      if (ta_nxt && dc_nxt == tidlms_pkg::DIG_W'(tidlms_pkg::ID_DIGITS)) begin
        found = 1'b1;
        value = acc_nxt;
      end
      mode_nxt = tidlms_pkg::MODE_LINE_START;
      pws_nxt  = 1'b1;
      dc_nxt   = '0;
      ta_nxt   = 1'b0;
      acc_nxt  = '0;
    end

    max_nxt = (found && value > max_r) ? value : max_r;

    res.token_found = found;
    res.token_value = value;
    res.max_value   = max_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tidlms_pkg::MODE_LINE_START;
      pws_r  <= 1'b1;
      dc_r   <= '0;
      ta_r   <= 1'b0;
      acc_r  <= '0;
      max_r  <= '0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      pws_r  <= pws_nxt;
      dc_r   <= dc_nxt;
      ta_r   <= ta_nxt;
      acc_r  <= acc_nxt;
      max_r  <= max_nxt;
    end
  end

endmodule

// ===== rtl/core/tidlms_out_stage.sv =====
// result register stage for the id list scanner
// depends on tidlms_pkg
module tidlms_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  tidlms_pkg::res_beat_t up_res,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output tidlms_pkg::res_beat_t dn_res
);

  logic                  valid_r;
  tidlms_pkg::res_beat_t res_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_valid && up_ready) begin
      valid_r <= 1'b1;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      res_r <= up_res;
    end
  end

endmodule

// ===== rtl/core/tagged_id_list_max_scanner_top.sv =====
// channel   | ports                                              | handshake
// input     | in_text_byte, in_file_start, in_file_end           | in_valid / in_ready
// result    | out_token_found, out_token_value, out_max_value    | out_valid / out_ready
//
// one result beat per input beat; the scanner state updates as a beat moves into the result register
// sustains one beat per cycle while out_ready is high, via the input register and result register
// rst_n is synchronous: scanner at line start, running maximum cleared
// a stalled result holds; the input register still takes one more beat behind it
// depends on tidlms_pkg, tidlms_in_stage, tidlms_scan, tidlms_out_stage and the defines header
`include "tagged_id_list_max_scanner_top_defines.svh"

module tagged_id_list_max_scanner_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_file_start,
  input  logic        in_file_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_token_found,
  output logic [19:0] out_token_value,
  output logic [19:0] out_max_value
);

  tidlms_pkg::in_beat_t  in_beat;
  tidlms_pkg::in_beat_t  s1_beat;
  tidlms_pkg::res_beat_t s1_res;
  tidlms_pkg::res_beat_t out_res;
  logic                  s1_valid;
  logic                  s2_ready;
  logic                  adv;

  assign in_beat.text_byte  = in_text_byte;
  assign in_beat.file_start = in_file_start;
  assign in_beat.file_end   = in_file_end;

  assign adv = s1_valid && s2_ready;

  tidlms_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_beat  (in_beat),
    .dn_valid (s1_valid),
    .dn_ready (s2_ready),
    .dn_beat  (s1_beat)
  );

  tidlms_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .beat  (s1_beat),
    .res   (s1_res)
  );

  tidlms_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_res   (s1_res),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_res   (out_res)
  );

  assign out_token_found = out_res.token_found;
  assign out_token_value = out_res.token_value;
  assign out_max_value   = out_res.max_value;

  `TIDLMS_ASSERT_NOW(a_max_covers_token, clk, rst_n, out_valid && out_token_found, out_max_value >= out_token_value)
  `TIDLMS_ASSERT_NOW(a_value_zero_no_token, clk, rst_n, out_valid && !out_token_found, out_token_value == 20'd0)
  `TIDLMS_ASSERT_NOW(a_busy_only_on_stall, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule
